// ===== hdl/hgn_pkg.sv =====
// Shared types and constants of the grayscale histogram unit.
`default_nettype none

package hgn_pkg;

   // Field widths of the stream words.
   localparam int PIXEL_W  = 12;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 16;
   localparam int SHARE_W  = 17;

   // Pixel values run 0..MAX_VALUE, and MAX_VALUE + 1 is a power of two,
   // so the bin of a value is (value * bins) >> VALUE_W.
   localparam int MAX_VALUE = 255;
   localparam int VALUE_W   = $clog2(MAX_VALUE + 1);

   // Widest bin address that the bin count range can need.
   localparam int BIN_W = 8;

   localparam int REQ_DATA_W = ((PIXEL_W + INDEX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + CNT_W + SHARE_W + 7) / 8) * 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CNT_W-1:0]   EXPECTED_RESET = 16'd16384;
   localparam logic [SHARE_W-1:0] SHARE_ONE      = 17'h10000;

   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_FINISH,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_RANGE,
      ERR_MISMATCH,
      ERR_OVERFLOW
   } err_type;

   // One classified word as it waits in the queue.
   typedef struct packed {
      op_type           op;
      logic             value_ok;
      logic             read_ok;
      logic [BIN_W-1:0] bin;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SHARE_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/gray_histogram_64bin_normalize_unit.sv =====
// Top level of the grayscale histogram unit with normalized bin read-out.
//
// Words enter on the req_ stream: req_tuser carries the operation (pixel,
// finish, read bin, clear) and req_tdata the pixel value and the bin index.
// Every word yields exactly one rsp_ word with the latched status, and on a
// bin read the raw count and its share of the pixel total in UQ1.16.
// csr_wen/csr_wdata set the pixel total that a finish word expects.
//
// A pixel, finish or clear word passes from the queue through the back
// end's second stage into the output register behind rsp_tvalid, and such
// words stream at one per cycle while rsp_tready stays high. A bin read
// with a nonzero count and total runs the share through a one-bit-per-cycle
// divider and holds the back end until it is done; other reads behave like
// pixel words. Results always leave in the order the words came in.
//
// Reset clears the bins (through per-bin valid flags), the pixel total, the
// error latch and the queue, and loads 16384 as the expected total; the unit
// takes words in the first cycle after reset. When the receiver holds
// rsp_tready low, one result waits in the output register, the back end
// stops, and the four-word queue keeps taking words until it fills.
`default_nettype none

module gray_histogram_64bin_normalize_unit import hgn_pkg::*; #(
   parameter int NUM_BINS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pixel_value[11:0], bin_index[17:12], zero pad
   input  logic [1:0]            req_tuser,  // op[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // status[1:0], bin_count[17:2],
                                             // bin_share[34:18], zero pad
   input  logic                  csr_wen,
   input  logic [CNT_W-1:0]      csr_wdata
);

   item_type           front_item;
   item_type           q_head;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic               q_push;
   err_type            rsp_status;
   logic [CNT_W-1:0]   rsp_count;
   logic [SHARE_W-1:0] rsp_share;

   // The queue takes a word whenever it has room; the back end drains it.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   hgn_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .req_op      (req_tuser),
      .pixel_value (req_tdata[PIXEL_W-1:0]),
      .bin_index   (req_tdata[PIXEL_W +: INDEX_W]),
      .item        (front_item)
   );

   hgn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   hgn_back #(
      .NUM_BINS (NUM_BINS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .rsp_share  (rsp_share)
   );

   // Result word: status in the low bits, then the count, then the share.
   assign rsp_tdata = RSP_DATA_W'({rsp_share, rsp_count, rsp_status});

endmodule

`default_nettype wire

// ===== hdl/hgn_front.sv =====
// Front end: decodes and range-checks an incoming word and finds its bin.
`default_nettype none

module hgn_front import hgn_pkg::*; #(
   parameter int NUM_BINS = 64
) (
   input  logic [1:0]                req_op,
   input  logic signed [PIXEL_W-1:0] pixel_value,
   input  logic [INDEX_W-1:0]        bin_index,
   output item_type                  item
);

   localparam int PROD_W = VALUE_W + BIN_W + 1;

   logic [PROD_W-1:0] prod;

   always_comb begin
      prod          = PROD_W'(pixel_value[VALUE_W-1:0]) * PROD_W'(NUM_BINS);
      item.op       = op_type'(req_op);
      item.value_ok = !pixel_value[PIXEL_W-1] &&
                      (pixel_value[PIXEL_W-2:0] <= (PIXEL_W-1)'(MAX_VALUE));
      item.read_ok  = ((BIN_W+1)'(bin_index) < (BIN_W+1)'(NUM_BINS));
      if (item.op == OP_READ) begin
         item.bin = BIN_W'(bin_index);
      end else begin
         item.bin = prod[VALUE_W +: BIN_W];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hgn_queue.sv =====
// Short queue of classified words between the front end and the back end.
`default_nettype none

module hgn_queue import hgn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head
);

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     fill_ff, fill_in;

   always_comb begin
      full      = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
      valid     = (fill_ff != '0);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hgn_div.sv =====
// Radix-2 restoring divider that forms a bin share, one quotient bit a cycle.
`default_nettype none

module hgn_div import hgn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEP_W = $clog2(SHARE_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [SHARE_W-1:0] bits_ff, bits_in;
   logic [SHARE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   dvs_ff, dvs_in;
   logic               sat_ff, sat_in;
   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     diff;
   logic               fits;

   // The dividend is count * 2^16. Its upper bits, count >> 1, seed the
   // remainder; when they already reach the divisor the share saturates.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      sat_in  = sat_ff;
      trial   = {rem_ff, bits_ff[SHARE_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = {1'b0, req.dividend[CNT_W-1:1]};
         bits_in = {req.dividend[0], {(SHARE_W-1){1'b0}}};
         quo_in  = '0;
         dvs_in  = req.divisor;
         sat_in  = ({1'b0, req.dividend[CNT_W-1:1]} >= req.divisor);
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SHARE_W-2:0], fits};
         bits_in = {bits_ff[SHARE_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SHARE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rsp.done     = done_ff;
      rsp.quotient = sat_ff ? SHARE_ONE : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      sat_ff  <= sat_in;
   end

endmodule

`default_nettype wire

// ===== hdl/hgn_back.sv =====
// Back end: counters, error latch, bin store with write forwarding, read-out.
`default_nettype none

module hgn_back import hgn_pkg::*; #(
   parameter int NUM_BINS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [CNT_W-1:0]   csr_wdata,
   input  logic               q_valid,
   input  item_type           q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output err_type            rsp_status,
   output logic [CNT_W-1:0]   rsp_count,
   output logic [SHARE_W-1:0] rsp_share
);

   localparam int ADDR_W = $clog2(NUM_BINS);

   logic [CNT_W-1:0]    mem [NUM_BINS];
   logic [CNT_W-1:0]    rdata_ff;
   logic                rvalid_ff;
   logic [NUM_BINS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   err_type             err_ff, err_in;
   logic [CNT_W-1:0]    expected_ff;

   logic                lw_valid_ff, lw_valid_in;
   logic [ADDR_W-1:0]   lw_addr_ff, lw_addr_in;
   logic [CNT_W-1:0]    lw_data_ff, lw_data_in;

   logic                b_valid_ff, b_valid_in;
   op_type              b_op_ff, b_op_in;
   logic                b_count_en_ff, b_count_en_in;
   logic                b_read_ok_ff, b_read_ok_in;
   logic [ADDR_W-1:0]   b_addr_ff, b_addr_in;
   err_type             b_status_ff, b_status_in;
   logic [CNT_W-1:0]    b_total_ff, b_total_in;
   logic                b_div_ff, b_div_in;

   logic                rsp_valid_ff, rsp_valid_in;
   err_type             rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [SHARE_W-1:0]  rsp_share_ff, rsp_share_in;

   logic [ADDR_W-1:0]   a_addr;
   logic                a_adv;
   logic                out_free;
   logic [CNT_W-1:0]    fwd;
   logic [CNT_W-1:0]    cur_count;
   logic [CNT_W-1:0]    inc_data;
   logic                needs_div;
   logic                div_go;
   logic                b_finish;
   logic                wr_en;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   hgn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      valid_in      = valid_ff;
      total_in      = total_ff;
      err_in        = err_ff;
      lw_valid_in   = lw_valid_ff;
      lw_addr_in    = lw_addr_ff;
      lw_data_in    = lw_data_ff;
      b_valid_in    = b_valid_ff;
      b_op_in       = b_op_ff;
      b_count_en_in = b_count_en_ff;
      b_read_ok_in  = b_read_ok_ff;
      b_addr_in     = b_addr_ff;
      b_status_in   = b_status_ff;
      b_total_in    = b_total_ff;
      b_div_in      = b_div_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_share_in  = rsp_share_ff;

      a_addr   = q_head.bin[ADDR_W-1:0];
      out_free = !rsp_valid_ff || rsp_ready;

      // The store is read at the edge that moves the bin into the second stage,
      // so it misses the write made at that edge; the last write is forwarded over the stored word.
      if (lw_valid_ff && (lw_addr_ff == b_addr_ff)) begin
         fwd = lw_data_ff;
      end else if (rvalid_ff) begin
         fwd = rdata_ff;
      end else begin
         fwd = '0;
      end
      cur_count = ((b_op_ff == OP_READ) && b_read_ok_ff) ? fwd : '0;
      inc_data  = (fwd == '1) ? fwd : fwd + 1'b1;
      needs_div = (b_op_ff == OP_READ) && (cur_count != '0) && (b_total_ff != '0);
      div_go    = b_valid_ff && needs_div && !b_div_ff;
      b_finish  = b_valid_ff && out_free && (!needs_div || (b_div_ff && div_rsp.done));
      wr_en     = b_finish && b_count_en_ff;
      a_adv     = q_valid && (!b_valid_ff || b_finish);
      q_pop     = a_adv;

      div_req.start    = div_go;
      div_req.dividend = cur_count;
      div_req.divisor  = b_total_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (b_finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = b_status_ff;
         rsp_count_in  = cur_count;
         rsp_share_in  = needs_div ? div_rsp.quotient : '0;
         b_valid_in    = 1'b0;
         b_div_in      = 1'b0;
      end
      if (div_go) begin
         b_div_in = 1'b1;
      end
      if (wr_en) begin
         lw_valid_in         = 1'b1;
         lw_addr_in          = b_addr_ff;
         lw_data_in          = inc_data;
         valid_in[b_addr_ff] = 1'b1;
      end

      // First stage: every decision on the totals and the error latch is
      // taken here, in word order, so the second stage touches only bins, the divider and the result.
      if (a_adv) begin
         b_valid_in    = 1'b1;
         b_op_in       = q_head.op;
         b_addr_in     = a_addr;
         b_read_ok_in  = q_head.read_ok;
         b_count_en_in = 1'b0;
         b_total_in    = total_ff;
         b_div_in      = 1'b0;
         case (q_head.op)
            OP_PIXEL: begin
               if (err_ff == ERR_NONE) begin
                  if (!q_head.value_ok) begin
                     err_in = ERR_RANGE;
                  end else if (total_ff == '1) begin
                     err_in = ERR_OVERFLOW;
                  end else begin
                     total_in      = total_ff + 1'b1;
                     b_count_en_in = 1'b1;
                  end
               end
            end
            OP_FINISH: begin
               if ((err_ff == ERR_NONE) && (total_ff != expected_ff)) begin
                  err_in = ERR_MISMATCH;
               end
            end
            OP_READ: begin
               b_count_en_in = 1'b0;
            end
            OP_CLEAR: begin
               total_in    = '0;
               err_in      = ERR_NONE;
               valid_in    = '0;
               lw_valid_in = 1'b0;
            end
            default: begin
               b_count_en_in = 1'b0;
            end
         endcase
         b_status_in = err_in;
      end

      rsp_valid  = rsp_valid_ff;
      rsp_status = rsp_status_ff;
      rsp_count  = rsp_count_ff;
      rsp_share  = rsp_share_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         total_ff     <= '0;
         err_ff       <= ERR_NONE;
         expected_ff  <= EXPECTED_RESET;
         lw_valid_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         b_div_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         err_ff       <= err_in;
         lw_valid_ff  <= lw_valid_in;
         b_valid_ff   <= b_valid_in;
         b_div_ff     <= b_div_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            expected_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      lw_addr_ff    <= lw_addr_in;
      lw_data_ff    <= lw_data_in;
      b_op_ff       <= b_op_in;
      b_count_en_ff <= b_count_en_in;
      b_read_ok_ff  <= b_read_ok_in;
      b_addr_ff     <= b_addr_in;
      b_status_ff   <= b_status_in;
      b_total_ff    <= b_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_share_ff  <= rsp_share_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[b_addr_ff] <= inc_data;
      end
      if (a_adv) begin
         rdata_ff  <= mem[a_addr];
         rvalid_ff <= valid_ff[a_addr];
      end
   end

endmodule

`default_nettype wire
